>>> rtl/mfvp_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio frame probe package
// Shared types, constants and lookup tables for the frame header probe.
// ----------------------------------------------------------------------------
package mfvp_pkg;

   localparam logic [10:0] SYNC_PATTERN = 11'h7ff;
   localparam logic [31:0] XING_WORD    = 32'h58696E67;
   localparam logic [31:0] XFLAG_FRAMES = 32'h0000_0001;
   localparam logic [31:0] XFLAG_BYTES  = 32'h0000_0002;
   localparam logic [30:0] SAT31        = 31'h7FFF_FFFF;

   localparam int DIV_W   = 51;
   localparam int DEN_W   = 43;
   localparam int DVSR_W  = 44;
   localparam int DCNT_W  = 6;

   typedef struct packed {
      logic load;
      logic decode;
      logic fetch;
      logic fld_init;
      logic resume;
      logic eval;
      logic mul;
      logic div_a;
      logic div_b;
      logic take_a;
      logic take_b;
   } cmd_type;

   typedef struct packed {
      logic hdr_bad;
      logic no_scan;
      logic win_full;
      logic cand_out;
      logic tag_hit;
      logic fld_done;
      logic accept_ok;
      logic has_counts;
      logic frames_zero;
      logic div_done;
   } sts_type;

   function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] layer,
                                              input logic [3:0] bidx);
      logic [8:0] v;
      v = 9'd0;
      if (lsf) begin
         case (layer)
            2'd1: begin
               case (bidx)
                  4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;
                  4'd4: v = 9'd128;  4'd5: v = 9'd160;  4'd6: v = 9'd192;
                  4'd7: v = 9'd224;  4'd8: v = 9'd256;  4'd9: v = 9'd288;
                  4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
                  4'd13: v = 9'd416; 4'd14: v = 9'd448;
                  default: v = 9'd0;
               endcase
            end
            2'd2: begin
               case (bidx)
                  4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
                  4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
                  4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd160;
                  4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
                  4'd13: v = 9'd320; 4'd14: v = 9'd384;
                  default: v = 9'd0;
               endcase
            end
            default: begin
               case (bidx)
                  4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;
                  4'd4: v = 9'd56;   4'd5: v = 9'd64;   4'd6: v = 9'd80;
                  4'd7: v = 9'd96;   4'd8: v = 9'd112;  4'd9: v = 9'd128;
                  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
                  4'd13: v = 9'd256; 4'd14: v = 9'd320;
                  default: v = 9'd0;
               endcase
            end
         endcase
      end else if (layer == 2'd1) begin
         case (bidx)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
            4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
            4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd144;
            4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
            4'd13: v = 9'd224; 4'd14: v = 9'd256;
            default: v = 9'd0;
         endcase
      end else begin
         case (bidx)
            4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;
            4'd4: v = 9'd32;   4'd5: v = 9'd40;   4'd6: v = 9'd48;
            4'd7: v = 9'd56;   4'd8: v = 9'd64;   4'd9: v = 9'd80;
            4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
            4'd13: v = 9'd144; 4'd14: v = 9'd160;
            default: v = 9'd0;
         endcase
      end
      return v;
   endfunction

   function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] fidx);
      logic [15:0] v;
      v = 16'd0;
      case ({ver, fidx})
         4'b00_00: v = 16'd44100;
         4'b00_01: v = 16'd48000;
         4'b00_10: v = 16'd32000;
         4'b01_00: v = 16'd22050;
         4'b01_01: v = 16'd24000;
         4'b01_10: v = 16'd16000;
         4'b10_00: v = 16'd11025;
         4'b10_01: v = 16'd12000;
         4'b10_10: v = 16'd8000;
         default:  v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [30:0] sat31(input logic [DIV_W-1:0] v);
      return (v > DIV_W'(SAT31)) ? SAT31 : v[30:0];
   endfunction

endpackage

>>> rtl/mp3_frame_header_vbr_probe_unit.sv
// ----------------------------------------------------------------------------
// MPEG audio frame header probe with VBR tag detection
// Bytes load one per cycle while busy is low. After the byte marked last,
// busy stays high while the unit decodes the header, scans the byte store
// for a Xing tag through a single read port (start offset by start offset,
// reading and checking the fields of a found tag and restarting the scan
// when it is rejected), then, when counts are present and the frame count
// is non-zero, multiplies and runs two restoring divisions of 51 quotient
// bits. The result appears for one cycle on rsp_valid and must be taken
// then; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module mp3_frame_header_vbr_probe_unit #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   output logic        rsp_header_ok,
   output logic [1:0]  rsp_mpeg_version,
   output logic [30:0] rsp_bit_rate,
   output logic [15:0] rsp_sample_rate,
   output logic [1:0]  rsp_channel_count,
   output logic        rsp_is_vbr,
   output logic        rsp_duration_valid,
   output logic [30:0] rsp_duration_seconds,
   output logic        rsp_zero_frames_fault
);

   mfvp_pkg::cmd_type cmd;
   mfvp_pkg::sts_type sts;

   mfvp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_byte (req_last_byte),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   mfvp_dp #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_header_ok         (rsp_header_ok),
      .rsp_mpeg_version      (rsp_mpeg_version),
      .rsp_bit_rate          (rsp_bit_rate),
      .rsp_sample_rate       (rsp_sample_rate),
      .rsp_channel_count     (rsp_channel_count),
      .rsp_is_vbr            (rsp_is_vbr),
      .rsp_duration_valid    (rsp_duration_valid),
      .rsp_duration_seconds  (rsp_duration_seconds),
      .rsp_zero_frames_fault (rsp_zero_frames_fault)
   );

endmodule

>>> rtl/mfvp_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle; divisor must be non-zero.
// ----------------------------------------------------------------------------
module mfvp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mfvp_pkg::DIV_W-1:0]        dividend,
   input  logic [mfvp_pkg::DVSR_W-1:0]       divisor,
   output logic                              done,
   output logic [mfvp_pkg::DIV_W-1:0]        quotient
);

   logic [mfvp_pkg::DVSR_W-1:0] rem_ff, rem_in;
   logic [mfvp_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [mfvp_pkg::DVSR_W-1:0] dvsr_ff;
   logic [mfvp_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [mfvp_pkg::DVSR_W:0]   trial;
   logic                        ge;

   assign trial = {rem_ff, quo_ff[mfvp_pkg::DIV_W-1]};
   assign ge    = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? mfvp_pkg::DVSR_W'(trial - {1'b0, dvsr_ff})
                     : trial[mfvp_pkg::DVSR_W-1:0];
         quo_in = {quo_ff[mfvp_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mfvp_pkg::DCNT_W'(mfvp_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/mfvp_dp.sv
// ----------------------------------------------------------------------------
// Probe datapath
// Byte store, header decode, tag scan window, field capture and arithmetic.
// ----------------------------------------------------------------------------
module mfvp_dp #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfvp_pkg::cmd_type       cmd,
   output mfvp_pkg::sts_type       sts,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_header_ok,
   output logic [1:0]              rsp_mpeg_version,
   output logic [30:0]             rsp_bit_rate,
   output logic [15:0]             rsp_sample_rate,
   output logic [1:0]              rsp_channel_count,
   output logic                    rsp_is_vbr,
   output logic                    rsp_duration_valid,
   output logic [30:0]             rsp_duration_seconds,
   output logic                    rsp_zero_frames_fault
);

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = CW + 8;

   logic [7:0]    mem_ff [BUFFER_BYTES];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff;
   logic [31:0]   hdr_ff;
   logic [PW-1:0] ptr_ff, tag_pos_ff;
   logic          rvalid_ff;
   logic [7:0]    rdata_ff;
   logic [3:0]    got_ff;
   logic [95:0]   sh_ff;
   logic [5:0]    off_ff;
   logic [10:0]   spf_ff;
   logic [15:0]   fs_ff;
   logic [31:0]   frames_ff, nbytes_ff;
   logic [mfvp_pkg::DIV_W-1:0] num_ff;
   logic [mfvp_pkg::DEN_W-1:0] den_ff;

   logic          ok_ff, vbr_ff, dv_ff, fault_ff;
   logic [1:0]    ver_ff, ch_ff;
   logic [30:0]   br_ff, dur_ff;

   logic          room;
   logic [AW-1:0] raddr;
   logic          shift_en;
   logic [31:0]   win_in;

   logic          v25, lsf, mono, bad;
   logic [1:0]    lbits, ver_idx, fidx;
   logic [3:0]    bidx;
   logic [5:0]    off_c;
   logic [10:0]   spf_c;
   logic [30:0]   br_c;

   logic [31:0]   flags, frames_c, nbytes_c;
   logic          nf, nb;
   logic [PW-1:0] end_pos;

   logic          div_start, div_done;
   logic [mfvp_pkg::DIV_W-1:0]  div_dvd, div_quo;
   logic [mfvp_pkg::DVSR_W-1:0] div_dvs;

   assign room  = (count_ff < CW'(BUFFER_BYTES));
   assign raddr = (ptr_ff < PW'(BUFFER_BYTES)) ? ptr_ff[AW-1:0] : '0;
   assign count_in = room ? CW'(count_ff + 1'b1) : count_ff;

   assign v25     = hdr_ff[20];
   assign lsf     = hdr_ff[19];
   assign lbits   = hdr_ff[18:17];
   assign bidx    = hdr_ff[15:12];
   assign fidx    = hdr_ff[11:10];
   assign mono    = (hdr_ff[7:6] == 2'd3);
   assign ver_idx = v25 ? (lsf ? 2'd0 : 2'd1) : 2'd2;
   assign bad = (len_ff < CW'(4)) || (hdr_ff[31:21] != mfvp_pkg::SYNC_PATTERN)
              || (!v25 && lsf) || (lbits == 2'd0) || (bidx == 4'd0) || (bidx == 4'd15)
              || (fidx == 2'd3);
   assign off_c = lsf ? (mono ? 6'd21 : 6'd36) : (mono ? 6'd13 : 6'd21);
   assign spf_c = (lbits == 2'd3) ? 11'd384 : ((lbits == 2'd1 && !lsf) ? 11'd576 : 11'd1152);
   assign br_c  = 31'(19'(mfvp_pkg::kbps_lookup(lsf, 2'(3'd4 - {1'b0, lbits}), bidx))
                      * 19'd1000);

   assign shift_en = cmd.fetch && rvalid_ff;
   assign win_in   = {sh_ff[23:0], rdata_ff};

   assign flags    = sh_ff[95:64];
   assign nf       = |(flags & mfvp_pkg::XFLAG_FRAMES);
   assign nb       = |(flags & mfvp_pkg::XFLAG_BYTES);
   assign frames_c = nf ? sh_ff[63:32] : 32'd0;
   assign nbytes_c = nb ? (nf ? sh_ff[31:0] : sh_ff[63:32]) : 32'd0;
   assign end_pos  = tag_pos_ff + PW'(108) + (nf ? PW'(4) : PW'(0)) + (nb ? PW'(4) : PW'(0));

   assign sts.hdr_bad     = bad;
   assign sts.no_scan     = (len_ff < CW'(5));
   assign sts.win_full    = shift_en && (got_ff >= 4'd3);
   assign sts.cand_out    = (ptr_ff >= PW'(off_ff) + PW'(len_ff));
   assign sts.tag_hit     = (win_in == mfvp_pkg::XING_WORD);
   assign sts.fld_done    = shift_en && (got_ff == 4'd11);
   assign sts.accept_ok   = (end_pos < PW'(len_ff));
   assign sts.has_counts  = nf || nb;
   assign sts.frames_zero = (frames_c == 32'd0);
   assign sts.div_done    = div_done;

   assign div_start = cmd.div_a || cmd.div_b;
   assign div_dvd   = cmd.div_b ? mfvp_pkg::DIV_W'(den_ff) : num_ff;
   assign div_dvs   = cmd.div_b ? mfvp_pkg::DVSR_W'(fs_ff) : mfvp_pkg::DVSR_W'(den_ff);

   mfvp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         mem_ff[count_ff[AW-1:0]] <= req_data_byte;
      end
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         got_ff    <= '0;
      end else begin
         if (cmd.load) begin
            count_ff <= req_last_byte ? '0 : count_in;
         end
         if (cmd.decode || cmd.resume) begin
            rvalid_ff <= 1'b0;
            got_ff    <= '0;
         end else begin
            rvalid_ff <= cmd.fetch;
            if (cmd.fld_init) begin
               got_ff <= '0;
            end else if (shift_en && got_ff != 4'd15) begin
               got_ff <= got_ff + 4'd1;
            end
         end
      end

      if (cmd.load) begin
         if (count_ff < CW'(4)) begin
            hdr_ff <= {hdr_ff[23:0], req_data_byte};
         end
         if (req_last_byte) begin
            len_ff <= count_in;
         end
      end

      if (cmd.decode) begin
         ptr_ff <= PW'(off_c);
      end else if (cmd.resume) begin
         ptr_ff <= tag_pos_ff + PW'(1);
      end else if (cmd.fetch) begin
         ptr_ff <= ptr_ff + PW'(1);
      end

      if (shift_en) begin
         sh_ff <= {sh_ff[87:0], rdata_ff};
      end
      if (cmd.fld_init) begin
         tag_pos_ff <= ptr_ff - PW'(4);
      end

      if (cmd.decode) begin
         off_ff   <= off_c;
         spf_ff   <= spf_c;
         fs_ff    <= bad ? 16'd0 : mfvp_pkg::rate_lookup(ver_idx, fidx);
         ok_ff    <= !bad;
         ver_ff   <= bad ? 2'd0 : 2'(ver_idx + 2'd1);
         br_ff    <= bad ? 31'd0 : br_c;
         ch_ff    <= bad ? 2'd0 : (mono ? 2'd1 : 2'd2);
         vbr_ff   <= 1'b0;
         dv_ff    <= 1'b0;
         dur_ff   <= 31'd0;
         fault_ff <= 1'b0;
      end

      if (cmd.eval) begin
         frames_ff <= frames_c;
         nbytes_ff <= nbytes_c;
         if (sts.accept_ok) begin
            vbr_ff <= 1'b1;
            if ((nf || nb) && frames_c == 32'd0) begin
               fault_ff <= 1'b1;
            end
         end
      end

      if (cmd.mul) begin
         num_ff <= mfvp_pkg::DIV_W'({48'(nbytes_ff) * 48'(fs_ff), 3'b000});
         den_ff <= mfvp_pkg::DEN_W'(frames_ff) * mfvp_pkg::DEN_W'(spf_ff);
      end
      if (cmd.take_a) begin
         br_ff <= mfvp_pkg::sat31(div_quo);
      end
      if (cmd.take_b) begin
         dur_ff <= mfvp_pkg::sat31(div_quo);
         dv_ff  <= 1'b1;
      end
   end

   assign rsp_header_ok         = ok_ff;
   assign rsp_mpeg_version      = ver_ff;
   assign rsp_bit_rate          = br_ff;
   assign rsp_sample_rate       = fs_ff;
   assign rsp_channel_count     = ch_ff;
   assign rsp_is_vbr            = vbr_ff;
   assign rsp_duration_valid    = dv_ff;
   assign rsp_duration_seconds  = dur_ff;
   assign rsp_zero_frames_fault = fault_ff;

endmodule

>>> rtl/mfvp_ctrl.sv
// ----------------------------------------------------------------------------
// Probe controller
// Sequences loading, header decode, tag scan, field checks, multiply and division.
// ----------------------------------------------------------------------------
module mfvp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last_byte,
   input  mfvp_pkg::sts_type  sts,
   output mfvp_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_FIELDS, S_EVAL, S_MUL,
      S_DIVA_GO, S_DIVA_WAIT, S_DIVB_GO, S_DIVB_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start && req_last_byte) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = (sts.hdr_bad || sts.no_scan) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd.fetch = 1'b1;
            if (sts.win_full) begin
               if (sts.cand_out) begin
                  state_in = S_DONE;
               end else if (sts.tag_hit) begin
                  cmd.fld_init = 1'b1;
                  state_in     = S_FIELDS;
               end
            end
         end
         S_FIELDS: begin
            cmd.fetch = 1'b1;
            if (sts.fld_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (!sts.accept_ok) begin
               cmd.resume = 1'b1;
               state_in   = S_SCAN;
            end else if (sts.has_counts && !sts.frames_zero) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVA_GO;
         end
         S_DIVA_GO: begin
            cmd.div_a = 1'b1;
            state_in  = S_DIVA_WAIT;
         end
         S_DIVA_WAIT: begin
            if (sts.div_done) begin
               cmd.take_a = 1'b1;
               state_in   = S_DIVB_GO;
            end
         end
         S_DIVB_GO: begin
            cmd.div_b = 1'b1;
            state_in  = S_DIVB_WAIT;
         end
         S_DIVB_WAIT: begin
            if (sts.div_done) begin
               cmd.take_b = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

>>> rtl/mfvp_checker.sv
// ----------------------------------------------------------------------------
// Probe port checker
// Port-level checks on result strobes, non-final byte transfers and result consistency.
// ----------------------------------------------------------------------------
module mfvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_header_ok,
   input logic [1:0]  rsp_mpeg_version,
   input logic [30:0] rsp_bit_rate,
   input logic        rsp_is_vbr,
   input logic        rsp_duration_valid,
   input logic        rsp_zero_frames_fault
);

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

   a_no_result_mid : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_byte) |=> (!busy && !rsp_valid))
      else $error("non-final byte transfer caused work");

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_header_ok) |->
         (rsp_mpeg_version == 2'd0 && rsp_bit_rate == 31'd0 && !rsp_is_vbr))
      else $error("rejected header carries data");

   a_vbr_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_duration_valid || rsp_zero_frames_fault)) |->
         (rsp_is_vbr && !(rsp_duration_valid && rsp_zero_frames_fault)))
      else $error("inconsistent tag flags");

endmodule

bind mp3_frame_header_vbr_probe_unit mfvp_checker u_mfvp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_last_byte         (req_last_byte),
   .rsp_valid             (rsp_valid),
   .rsp_header_ok         (rsp_header_ok),
   .rsp_mpeg_version      (rsp_mpeg_version),
   .rsp_bit_rate          (rsp_bit_rate),
   .rsp_is_vbr            (rsp_is_vbr),
   .rsp_duration_valid    (rsp_duration_valid),
   .rsp_zero_frames_fault (rsp_zero_frames_fault)
);
